// ===== sv/klock_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package klock_pkg;

    localparam int CODE_DIGITS = 8;
    localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int KEY_W       = 4;
    localparam int CNT_W       = 4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_DIGITS - 1);

    localparam logic [KEY_W-1:0] KEY_MAX_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_CHANGE    = 4'd13;
    localparam logic [KEY_W-1:0] KEY_END       = 4'd14;
    localparam logic [KEY_W-1:0] KEY_START     = 4'd15;
    localparam logic [KEY_W-1:0] RESET_DIGIT   = 4'd8;

    localparam logic [CNT_W-1:0] RESET_ATTEMPTS = 4'd3;
    localparam logic [CNT_W-1:0] FAIL_MAX       = 4'd15;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ENTER = 3'd1,
        PH_OPEN  = 3'd2,
        PH_NEW1  = 3'd3,
        PH_NEW2  = 3'd4,
        PH_LOCK  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        OC_NONE     = 3'd0,
        OC_WRONG    = 3'd1,
        OC_RIGHT    = 3'd2,
        OC_MISMATCH = 3'd3,
        OC_CHANGED  = 3'd4,
        OC_LOCKED   = 3'd5
    } t_outcome;

    typedef struct packed {
        logic             wr_entry;
        logic             wr_confirm;
        logic             commit;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
    } t_code_ctl;

    typedef struct packed {
        logic entry_match;
        logic confirm_match;
    } t_code_sts;

    typedef struct packed {
        t_phase           phase;
        logic [3:0]       digits;
        t_outcome         outcome;
        logic [CNT_W-1:0] failures;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/klock_codes.sv =====
`timescale 1ns / 1ps
`default_nettype none

module klock_codes (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire klock_pkg::t_code_ctl  i_ctl,
    output klock_pkg::t_code_sts       o_sts
);

    logic [klock_pkg::KEY_W-1:0] r_stored  [klock_pkg::CODE_DIGITS];
    logic [klock_pkg::KEY_W-1:0] r_entry   [klock_pkg::CODE_DIGITS];
    logic [klock_pkg::KEY_W-1:0] r_confirm [klock_pkg::CODE_DIGITS];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < klock_pkg::CODE_DIGITS; k++) begin
            if (!i_rst_n) begin
                r_stored[k] <= klock_pkg::RESET_DIGIT;
            end else if (i_ctl.commit) begin
                r_stored[k] <= r_entry[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_entry) begin
            r_entry[i_ctl.idx] <= i_ctl.key;
        end
        if (i_ctl.wr_confirm) begin
            r_confirm[i_ctl.idx] <= i_ctl.key;
        end
    end

    // compare with the digit of this press merged in at its position
    always_comb begin
        logic [klock_pkg::KEY_W-1:0] ent_d;
        logic [klock_pkg::KEY_W-1:0] cnf_d;
        o_sts.entry_match   = 1'b1;
        o_sts.confirm_match = 1'b1;
        for (int k = 0; k < klock_pkg::CODE_DIGITS; k++) begin
            ent_d = (i_ctl.idx == klock_pkg::IDX_W'(k)) ? i_ctl.key : r_entry[k];
            cnf_d = (i_ctl.idx == klock_pkg::IDX_W'(k)) ? i_ctl.key : r_confirm[k];
            if (ent_d != r_stored[k]) begin
                o_sts.entry_match = 1'b0;
            end
            if (cnf_d != r_entry[k]) begin
                o_sts.confirm_match = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/klock_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module klock_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic [klock_pkg::KEY_W-1:0]   i_key,
    input  wire logic [klock_pkg::CNT_W-1:0]   i_attempts,
    input  wire klock_pkg::t_code_sts          i_sts,
    output klock_pkg::t_code_ctl               o_ctl,
    output klock_pkg::t_result                 o_res
);

    klock_pkg::t_phase                r_phase, n_phase;
    logic [klock_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [klock_pkg::CNT_W-1:0]      r_failures, n_failures;
    klock_pkg::t_result               r_res;

    logic [klock_pkg::CNT_W-1:0]      fail_inc;
    logic                             digit;
    logic                             last;
    logic                             wr_entry;
    logic                             wr_confirm;
    logic                             commit;
    klock_pkg::t_outcome              outcome;

    assign digit    = (i_key <= klock_pkg::KEY_MAX_DIGIT);
    assign last     = (r_idx == klock_pkg::LAST_IDX);
    assign fail_inc = (r_failures != klock_pkg::FAIL_MAX) ? r_failures + 1'b1 : r_failures;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= klock_pkg::PH_IDLE;
            r_idx      <= '0;
            r_failures <= '0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_failures <= n_failures;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res.phase    <= n_phase;
            r_res.digits   <= 4'(n_idx);
            r_res.outcome  <= outcome;
            r_res.failures <= n_failures;
        end
    end

    always_comb begin
        logic judge;
        logic match;
        judge      = 1'b0;
        match      = 1'b0;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_failures = r_failures;
        outcome    = klock_pkg::OC_NONE;
        wr_entry   = 1'b0;
        wr_confirm = 1'b0;
        commit     = 1'b0;

        unique case (r_phase)
            klock_pkg::PH_IDLE: begin
                if (i_key == klock_pkg::KEY_START) begin
                    n_phase = klock_pkg::PH_ENTER;
                    n_idx   = '0;
                end
            end
            klock_pkg::PH_ENTER: begin
                if (digit) begin
                    wr_entry = 1'b1;
                    if (last) begin
                        judge = 1'b1;
                        match = i_sts.entry_match;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (i_key == klock_pkg::KEY_END) begin
                    judge = 1'b1;
                end
            end
            klock_pkg::PH_OPEN: begin
                if (i_key == klock_pkg::KEY_CHANGE) begin
                    n_phase = klock_pkg::PH_NEW1;
                    n_idx   = '0;
                end
            end
            klock_pkg::PH_NEW1: begin
                if (digit) begin
                    wr_entry = 1'b1;
                    if (last) begin
                        n_phase = klock_pkg::PH_NEW2;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            klock_pkg::PH_NEW2: begin
                if (digit) begin
                    wr_confirm = 1'b1;
                    if (last) begin
                        n_idx = '0;
                        if (i_sts.confirm_match) begin
                            commit  = 1'b1;
                            n_phase = klock_pkg::PH_IDLE;
                            outcome = klock_pkg::OC_CHANGED;
                        end else begin
                            n_phase = klock_pkg::PH_NEW1;
                            outcome = klock_pkg::OC_MISMATCH;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_phase = klock_pkg::PH_LOCK;
                outcome = klock_pkg::OC_LOCKED;
            end
        endcase

        if (judge) begin
            n_idx = '0;
            if (match) begin
                n_phase = klock_pkg::PH_OPEN;
                outcome = klock_pkg::OC_RIGHT;
            end else begin
                n_failures = fail_inc;
                if (fail_inc >= i_attempts) begin
                    n_phase = klock_pkg::PH_LOCK;
                    outcome = klock_pkg::OC_LOCKED;
                end else begin
                    n_phase = klock_pkg::PH_IDLE;
                    outcome = klock_pkg::OC_WRONG;
                end
            end
        end
    end

    always_comb begin
        o_ctl.wr_entry   = wr_entry && i_adv;
        o_ctl.wr_confirm = wr_confirm && i_adv;
        o_ctl.commit     = commit && i_adv;
        o_ctl.idx        = r_idx;
        o_ctl.key        = i_key;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== sv/keypad_code_lock.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                     Payload
// -------  ----------------------------  --------------------------------------------
// key in   i_in_valid / o_in_ready       i_key_code
// status   o_out_valid / i_out_ready     o_phase, o_digits_entered, o_outcome,
//                                        o_failure_count
// config   i_cfg_valid / o_cfg_ready     i_cfg_attempts_allowed
//
// One request per cycle sustained while the status output is not stalled; a key press is held
// in the input register, then the FSM step plus the parallel code compare writes the status
// register once the status output is free. Synchronous active-low reset sets the code to all
// eights, clears failures and the phase. A stalled status output holds back the input register
// and the FSM; the config channel is always ready.

module keypad_code_lock (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_key_code,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_phase,
    output logic [3:0]       o_digits_entered,
    output logic [2:0]       o_outcome,
    output logic [3:0]       o_failure_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_attempts_allowed
);

    logic                            r_in_valid;
    logic [klock_pkg::KEY_W-1:0]     r_key;
    logic                            r_out_valid;
    logic [klock_pkg::CNT_W-1:0]     r_attempts;
    logic                            adv;
    klock_pkg::t_code_ctl            code_ctl;
    klock_pkg::t_code_sts            code_sts;
    klock_pkg::t_result              res;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_attempts  <= klock_pkg::RESET_ATTEMPTS;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_attempts <= i_cfg_attempts_allowed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_key <= i_key_code;
        end
    end

    klock_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_key      (r_key),
        .i_attempts (r_attempts),
        .i_sts      (code_sts),
        .o_ctl      (code_ctl),
        .o_res      (res)
    );

    klock_codes u_codes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (code_ctl),
        .o_sts   (code_sts)
    );

    assign o_out_valid      = r_out_valid;
    assign o_phase          = res.phase;
    assign o_digits_entered = res.digits;
    assign o_outcome        = res.outcome;
    assign o_failure_count  = res.failures;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import klock_pkg::*;

    typedef logic [CODE_DIGITS-1:0][KEY_W-1:0] t_code;
    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} t_rdy_mode;

    localparam int DIGIT_BASE = KEY_MAX_DIGIT + 1;
    localparam int LONG_STALL = 400;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic [KEY_W-1:0] i_key_code = '0;
    logic             i_out_ready = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [CNT_W-1:0] i_cfg_attempts_allowed = '0;
    wire              o_in_ready;
    wire              o_out_valid;
    wire  [2:0]       o_phase;
    wire  [3:0]       o_digits_entered;
    wire  [2:0]       o_outcome;
    wire  [3:0]       o_failure_count;
    wire              o_cfg_ready;

    keypad_code_lock u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_key_code             (i_key_code),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_phase                (o_phase),
        .o_digits_entered       (o_digits_entered),
        .o_outcome              (o_outcome),
        .o_failure_count        (o_failure_count),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_attempts_allowed (i_cfg_attempts_allowed)
    );

    always #5 i_clk = ~i_clk;

    // lock state as the testbench sees it
    t_phase           lk_phase;
    int               lk_pos;
    logic [CNT_W-1:0] lk_fails;
    logic [CNT_W-1:0] lk_limit;
    t_code            lk_code;
    t_code            lk_entry;
    t_code            lk_confirm;

    t_result   status_q[$];
    int        mismatch_cnt = 0;
    int        burst_left = 0;
    bit        long_stall_req = 1'b0;
    int        stall_left = 0;
    int        mode_left = 0;
    t_rdy_mode ready_mode = RDY_ALWAYS;

    function automatic t_outcome grade_entry();
        if (lk_pos >= CODE_DIGITS && lk_entry == lk_code) begin
            lk_phase = PH_OPEN;
            lk_pos   = 0;
            return OC_RIGHT;
        end
        if (lk_fails != FAIL_MAX) lk_fails++;
        lk_pos = 0;
        if (lk_fails >= lk_limit) begin
            lk_phase = PH_LOCK;
            return OC_LOCKED;
        end
        lk_phase = PH_IDLE;
        return OC_WRONG;
    endfunction

    function automatic t_result press_key(logic [KEY_W-1:0] key);
        t_result  res;
        t_outcome oc;
        logic     is_digit;
        oc       = OC_NONE;
        is_digit = (key <= KEY_MAX_DIGIT);
        case (lk_phase)
            PH_IDLE: begin
                if (key == KEY_START) begin
                    lk_phase = PH_ENTER;
                    lk_pos   = 0;
                end
            end
            PH_ENTER: begin
                if (is_digit) begin
                    if (lk_pos < CODE_DIGITS) begin
                        lk_entry[lk_pos] = key;
                        lk_pos++;
                    end
                    if (lk_pos >= CODE_DIGITS) oc = grade_entry();
                end else if (key == KEY_END) begin
                    oc = grade_entry();
                end
            end
            PH_OPEN: begin
                if (key == KEY_CHANGE) begin
                    lk_phase = PH_NEW1;
                    lk_pos   = 0;
                end
            end
            PH_NEW1: begin
                if (is_digit) begin
                    if (lk_pos < CODE_DIGITS) begin
                        lk_entry[lk_pos] = key;
                        lk_pos++;
                    end
                    if (lk_pos >= CODE_DIGITS) begin
                        lk_phase = PH_NEW2;
                        lk_pos   = 0;
                    end
                end
            end
            PH_NEW2: begin
                if (is_digit) begin
                    if (lk_pos < CODE_DIGITS) begin
                        lk_confirm[lk_pos] = key;
                        lk_pos++;
                    end
                    if (lk_pos >= CODE_DIGITS) begin
                        lk_pos = 0;
                        if (lk_entry == lk_confirm) begin
                            lk_code  = lk_entry;
                            lk_phase = PH_IDLE;
                            oc       = OC_CHANGED;
                        end else begin
                            lk_phase = PH_NEW1;
                            oc       = OC_MISMATCH;
                        end
                    end
                end
            end
            default: begin
                lk_phase = PH_LOCK;
                oc       = OC_LOCKED;
            end
        endcase
        res.phase    = lk_phase;
        res.digits   = 4'(lk_pos);
        res.outcome  = oc;
        res.failures = lk_fails;
        return res;
    endfunction

    function automatic t_code rand_code();
        t_code c;
        for (int k = 0; k < CODE_DIGITS; k++) c[k] = KEY_W'($urandom_range(0, KEY_MAX_DIGIT));
        return c;
    endfunction

    task automatic log_error(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // one key request; prediction happens at the accepting edge
    task automatic send_key(logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_key_code <= key;
        do @(posedge i_clk); while (!o_in_ready);
        status_q.push_back(press_key(key));
        @(negedge i_clk);
    endtask

    task automatic send_code(t_code code);
        for (int k = 0; k < CODE_DIGITS; k++) send_key(code[k]);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] value);
        i_cfg_valid            <= 1'b1;
        i_cfg_attempts_allowed <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        lk_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly well-formed unlock and code-change sequences, some noise keys,
    // and wrong entries while the failure budget allows; ends in idle
    task automatic run_random(int n_items, logic [CNT_W-1:0] fail_cap);
        int               sent;
        int               bad_pos;
        bit               bad_short;
        t_phase           plan_phase;
        t_code            target;
        t_code            fresh_code;
        logic [KEY_W-1:0] key;
        sent       = 0;
        plan_phase = PH_LOCK;
        fresh_code = rand_code();
        target     = lk_code;
        bad_short  = 1'b0;
        bad_pos    = 0;
        while (sent < n_items || lk_phase != PH_IDLE) begin
            if (lk_phase != plan_phase) begin
                plan_phase = lk_phase;
                bad_short  = 1'b0;
                bad_pos    = $urandom_range(0, CODE_DIGITS - 1);
                case (lk_phase)
                    PH_ENTER: begin
                        target = lk_code;
                        if (lk_fails < fail_cap && lk_fails + 1 < lk_limit
                                && $urandom_range(0, 7) == 0) begin
                            if ($urandom_range(0, 1) == 1) begin
                                bad_short = 1'b1;
                            end else begin
                                target[bad_pos] = KEY_W'((int'(target[bad_pos])
                                    + $urandom_range(1, KEY_MAX_DIGIT)) % DIGIT_BASE);
                            end
                        end
                    end
                    PH_NEW1: begin
                        case ($urandom_range(0, 5))
                            0: fresh_code = '0;
                            1: fresh_code = {CODE_DIGITS{KEY_MAX_DIGIT}};
                            default: fresh_code = rand_code();
                        endcase
                        target = fresh_code;
                    end
                    PH_NEW2: begin
                        target = fresh_code;
                        if ($urandom_range(0, 3) == 0)
                            target[bad_pos] = KEY_W'((int'(target[bad_pos])
                                + $urandom_range(1, KEY_MAX_DIGIT)) % DIGIT_BASE);
                    end
                    default: ;
                endcase
            end
            if ($urandom_range(0, 7) == 0) begin
                case (lk_phase)
                    PH_IDLE: key = KEY_W'($urandom_range(0, KEY_END));
                    PH_ENTER: begin
                        key = KEY_W'($urandom_range(KEY_MAX_DIGIT + 1, KEY_END));
                        if (key == KEY_END) key = KEY_START;
                    end
                    PH_OPEN: begin
                        key = KEY_W'($urandom_range(0, KEY_START));
                        if (key == KEY_CHANGE) key = KEY_START;
                    end
                    default: key = KEY_W'($urandom_range(KEY_MAX_DIGIT + 1, KEY_START));
                endcase
                send_key(key);
            end else begin
                case (lk_phase)
                    PH_IDLE:  key = KEY_START;
                    PH_OPEN:  key = KEY_CHANGE;
                    PH_ENTER: key = (bad_short && lk_pos == bad_pos) ? KEY_END : target[lk_pos];
                    PH_NEW1, PH_NEW2: key = target[lk_pos];
                    default:  key = KEY_W'($urandom_range(0, KEY_START));
                endcase
                send_key(key);
                sent++;
            end
        end
    endtask

    // ---- tests

    task automatic test_short_entry();
        send_key(KEY_START);
        send_key(4'd0);
        send_key(4'd9);
        send_key(4'd5);
        send_key(KEY_END);
        send_key(KEY_START);
        send_key(KEY_END);
    endtask

    task automatic test_default_code();
        send_key(4'd0);
        send_key(4'd9);
        send_key(KEY_CHANGE);
        send_key(KEY_END);
        send_key(KEY_START);
        send_key(KEY_W'(KEY_MAX_DIGIT + 1));
        send_key(KEY_W'(KEY_CHANGE - 1));
        send_key(KEY_CHANGE);
        send_key(KEY_START);
        send_code({CODE_DIGITS{RESET_DIGIT}});
        send_key(4'd0);
        send_key(KEY_START);
        send_key(KEY_END);
    endtask

    task automatic test_random_max_limit();
        wait_idle();
        write_limit(FAIL_MAX);
        run_random(350, 4'd8);
    endtask

    task automatic test_backpressure();
        wait_idle();
        @(posedge i_clk);
        long_stall_req = 1'b1;
        @(negedge i_clk);
        run_random(60, 4'd8);
    endtask

    task automatic test_random_mid_limit();
        wait_idle();
        write_limit(CNT_W'($urandom_range(lk_fails + 2, FAIL_MAX)));
        run_random(350, CNT_W'(FAIL_MAX - 2));
    endtask

    task automatic test_lockout();
        wait_idle();
        write_limit(FAIL_MAX);
        while (lk_fails < FAIL_MAX - 1) begin
            send_key(KEY_START);
            send_key(KEY_END);
        end
        // limit below the count: next failure locks out
        wait_idle();
        write_limit('0);
        send_key(KEY_START);
        send_key(KEY_W'($urandom_range(0, KEY_MAX_DIGIT)));
        send_key(KEY_END);
        repeat (20) send_key(KEY_W'($urandom_range(0, KEY_START)));
    endtask

    // ---- receiver

    always @(negedge i_clk) begin
        if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left     = LONG_STALL;
        end
        if (mode_left == 0) begin
            mode_left  = $urandom_range(8, 120);
            ready_mode = t_rdy_mode'($urandom_range(0, 3));
        end
        mode_left--;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS: i_out_ready <= 1'b1;
                RDY_HALF:   i_out_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default:    i_out_ready <= mode_left[2];
            endcase
        end
    end

    always @(posedge i_clk) begin : chk_status
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (status_q.size() == 0) begin
                log_error($sformatf("status with no request pending: phase %0d outcome %0d",
                                    o_phase, o_outcome));
            end else begin
                want = status_q.pop_front();
                if (o_phase !== want.phase || o_digits_entered !== want.digits
                        || o_outcome !== want.outcome || o_failure_count !== want.failures)
                    log_error($sformatf(
                        "phase %0d/%0d digits %0d/%0d outcome %0d/%0d failures %0d/%0d (exp/act)",
                        want.phase, o_phase, want.digits, o_digits_entered,
                        want.outcome, o_outcome, want.failures, o_failure_count));
            end
        end
    end

    initial begin
        lk_phase   = PH_IDLE;
        lk_pos     = 0;
        lk_fails   = '0;
        lk_limit   = RESET_ATTEMPTS;
        lk_code    = {CODE_DIGITS{RESET_DIGIT}};
        lk_entry   = '0;
        lk_confirm = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_entry();
        test_default_code();
        test_random_max_limit();
        test_backpressure();
        test_random_mid_limit();
        test_lockout();
        wait_idle();
        if (mismatch_cnt == 0 && status_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
